@@ sv/psphr_pkg.sv @@
// Shared types and constants for the per-source packet history ring.
// Holds field widths, request and status codes, controller states and the
// command and status bundles between controller and datapath. No dependencies.
package psphr_pkg;

   localparam int RING_SIZE_DEF = 16;
   localparam int SOURCES_DEF   = 8;
   localparam int MAX_OUT       = 16;

   localparam int REQ_W     = 2;
   localparam int SRC_W     = 4;
   localparam int TURN_W    = 32;
   localparam int PAYLOAD_W = 64;
   localparam int STATUS_W  = 2;
   localparam int POS_W     = 4;
   localparam int DEPTH_W   = 5;
   localparam int CNT_W     = $clog2(MAX_OUT + 1);
   localparam int SLOT_W    = TURN_W + PAYLOAD_W;

   localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(2);

   typedef enum logic [REQ_W-1:0] {
      REQ_BUNDLE = 2'd0,
      REQ_STORE  = 2'd1,
      REQ_DUMP   = 2'd2,
      REQ_NONE   = 2'd3
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_PACKET     = 2'd0,
      ST_STORED     = 2'd1,
      ST_EMPTY      = 2'd2,
      ST_BAD_SOURCE = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_STATUS,
      S_CURRENT,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_FLUSH,
      S_SEARCH_RD,
      S_SEARCH_CHK,
      S_WRITE
   } state_type;

   typedef struct packed {
      logic capture;
      logic idx_clear;
      logic idx_inc;
      logic rd_en;
      logic rd_phys;
      logic gen_status;
      logic gen_current;
      logic gen_slot;
      logic flush;
      logic found_set;
      logic wr_en;
   } cmd_type;

   typedef struct packed {
      logic req_none;
      logic bad_source;
      logic is_store;
      logic is_dump;
      logic cnt_zero;
      logic depth_one;
      logic out_free;
      logic pend_valid;
      logic can_gen;
      logic emit_want;
      logic scan_more;
      logic turn_match;
      logic search_more;
   } sts_type;

endpackage

@@ sv/psphr_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Used for the packet slot store. No dependencies.
module psphr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/psphr_ctrl.sv @@
// Controller state machine for the packet history ring.
// Sequences decode, scan, search and write; depends on psphr_pkg.
module psphr_ctrl import psphr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      scan_go;

   // A slot that must be emitted cannot be taken while the pending item is stuck.
   assign scan_go = !(sts.emit_want && !sts.can_gen);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !sts.req_none) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (sts.bad_source) begin
               state_in = S_STATUS;
            end else if (sts.is_store) begin
               state_in = sts.cnt_zero ? S_WRITE : S_SEARCH_RD;
            end else if (sts.is_dump) begin
               state_in = sts.cnt_zero ? S_STATUS : S_SCAN_RD;
            end else begin
               state_in = S_CURRENT;
            end
         end
         S_STATUS: begin
            if (sts.out_free) state_in = S_IDLE;
         end
         S_CURRENT: begin
            state_in = (!sts.cnt_zero && !sts.depth_one) ? S_SCAN_RD : S_FLUSH;
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (scan_go && !sts.scan_more) state_in = S_FLUSH;
         end
         S_FLUSH: begin
            if (sts.out_free) begin
               if (sts.is_dump) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = sts.cnt_zero ? S_WRITE : S_SEARCH_RD;
               end
            end
         end
         S_SEARCH_RD: begin
            state_in = S_SEARCH_CHK;
         end
         S_SEARCH_CHK: begin
            if (sts.turn_match || !sts.search_more) state_in = S_WRITE;
         end
         S_WRITE: begin
            state_in = sts.is_store ? S_STATUS : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid && !sts.req_none;
         end
         S_STATUS: begin
            cmd.gen_status = sts.out_free;
         end
         S_CURRENT: begin
            cmd.gen_current = 1'b1;
         end
         S_SCAN_RD: begin
            cmd.idx_clear = 1'b1;
            cmd.rd_en     = 1'b1;
         end
         S_SCAN_CHK: begin
            cmd.gen_slot = scan_go && sts.emit_want;
            cmd.idx_inc  = scan_go && sts.scan_more;
            cmd.rd_en    = scan_go && sts.scan_more;
         end
         S_FLUSH: begin
            cmd.flush = sts.out_free;
         end
         S_SEARCH_RD: begin
            cmd.idx_clear = 1'b1;
            cmd.rd_en     = 1'b1;
            cmd.rd_phys   = 1'b1;
         end
         S_SEARCH_CHK: begin
            cmd.rd_phys   = 1'b1;
            cmd.found_set = sts.turn_match;
            cmd.idx_inc   = !sts.turn_match && sts.search_more;
            cmd.rd_en     = !sts.turn_match && sts.search_more;
         end
         S_WRITE: begin
            cmd.wr_en = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Nothing may be left pending once a request has finished.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !sts.pend_valid)
      else $error("pending item left over after request");

   // A status result always stands alone.
   assert property (@(posedge clock) disable iff (reset)
      cmd.gen_status |-> !sts.pend_valid)
      else $error("status result issued with a packet pending");

   // Flushing always has a packet to close the sequence with.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FLUSH |-> sts.pend_valid)
      else $error("flush without a pending packet");

endmodule

@@ sv/psphr_dp.sv @@
// Datapath for the packet history ring: request registers, ring pointers,
// slot RAM, pending and output item registers. Depends on psphr_pkg, psphr_ram.
module psphr_dp import psphr_pkg::*; #(
   parameter int RING_SIZE = RING_SIZE_DEF,
   parameter int SOURCES   = SOURCES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [REQ_W-1:0]     req_type,
   input  logic [SRC_W-1:0]     req_source,
   input  logic [TURN_W-1:0]    req_turn,
   input  logic [PAYLOAD_W-1:0] req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [TURN_W-1:0]    rsp_out_turn,
   output logic [PAYLOAD_W-1:0] rsp_out_payload,
   output logic [POS_W-1:0]     rsp_position,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [DEPTH_W-1:0]   csr_bundle_depth,
   input  cmd_type              cmd,
   output sts_type              sts
);

   localparam int SW    = $clog2(RING_SIZE);
   localparam int CW    = $clog2(RING_SIZE + 1);
   localparam int SIW   = (SOURCES > 1) ? $clog2(SOURCES) : 1;
   localparam int DEPTH = SOURCES * RING_SIZE;
   localparam int AW    = $clog2(DEPTH);

   // Request registers
   req_code_type         type_ff;
   logic [SRC_W-1:0]     src_ff;
   logic [TURN_W-1:0]    turn_ff;
   logic [PAYLOAD_W-1:0] payload_ff;
   logic [DEPTH_W-1:0]   depth_ff;

   // Ring bookkeeping
   logic [SW-1:0] wp_ff  [SOURCES];
   logic [CW-1:0] cnt_ff [SOURCES];
   logic [SW-1:0] wp_in;
   logic [CW-1:0] cnt_in;

   logic [CW-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic             found_ff;
   logic [SW-1:0]    found_slot_ff;

   // Pending item, held back until it is known whether it closes the sequence
   logic                 pend_valid_ff;
   logic [TURN_W-1:0]    pend_turn_ff;
   logic [PAYLOAD_W-1:0] pend_payload_ff;
   logic [POS_W-1:0]     pend_pos_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [TURN_W-1:0]    rsp_turn_ff;
   logic [PAYLOAD_W-1:0] rsp_payload_ff;
   logic [POS_W-1:0]     rsp_pos_ff;
   logic                 rsp_last_ff;

   logic [SIW-1:0]       src_idx;
   logic [SW-1:0]        cur_wp;
   logic [CW-1:0]        cur_cnt;
   logic [CW:0]          nw_sum;
   logic [SW-1:0]        newest_slot;
   logic [SW-1:0]        rd_slot;
   logic [SW-1:0]        wr_slot;
   logic [AW-1:0]        rd_addr;
   logic [AW-1:0]        wr_addr;
   logic [SLOT_W-1:0]    rd_data;
   logic [TURN_W-1:0]    ram_turn;
   logic [PAYLOAD_W-1:0] ram_payload;
   logic [CNT_W-1:0]     depth_eff;
   logic [CNT_W-1:0]     n_after;
   logic [CNT_W-1:0]     limit;
   logic                 idx_more;
   logic                 emit_want;
   logic                 out_free;
   logic                 push;
   logic [STATUS_W-1:0]  status_code;

   assign src_idx  = src_ff[SIW-1:0];
   assign cur_wp   = wp_ff[src_idx];
   assign cur_cnt  = cnt_ff[src_idx];
   assign ram_turn    = rd_data[SLOT_W-1 -: TURN_W];
   assign ram_payload = rd_data[PAYLOAD_W-1:0];

   always_comb begin
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + CW'(1);
      end else begin
         idx_in = idx_ff;
      end
   end

   // Age zero is the slot just behind the write pointer.
   always_comb begin
      nw_sum = (CW+1)'(cur_wp) + (CW+1)'(RING_SIZE - 1) - (CW+1)'(idx_in);
      if (nw_sum >= (CW+1)'(RING_SIZE)) begin
         newest_slot = SW'(nw_sum - (CW+1)'(RING_SIZE));
      end else begin
         newest_slot = SW'(nw_sum);
      end
   end

   assign rd_slot = cmd.rd_phys ? idx_in[SW-1:0] : newest_slot;
   assign wr_slot = found_ff ? found_slot_ff : cur_wp;
   assign rd_addr = AW'(int'(src_idx) * RING_SIZE + int'(rd_slot));
   assign wr_addr = AW'(int'(src_idx) * RING_SIZE + int'(wr_slot));

   psphr_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data ({turn_ff, payload_ff}),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      if (depth_ff == '0) begin
         depth_eff = CNT_W'(1);
      end else if (depth_ff > DEPTH_W'(MAX_OUT)) begin
         depth_eff = CNT_W'(MAX_OUT);
      end else begin
         depth_eff = CNT_W'(depth_ff);
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_want = (type_ff == REQ_DUMP) || (ram_turn != turn_ff);
   assign n_after   = n_ff + CNT_W'(emit_want);
   assign limit     = (type_ff == REQ_DUMP) ? CNT_W'(MAX_OUT) : depth_eff;
   assign idx_more  = ({1'b0, idx_ff} + (CW+1)'(1)) < {1'b0, cur_cnt};

   always_comb begin
      sts             = '0;
      sts.req_none    = (req_type == REQ_NONE);
      sts.bad_source  = !({1'b0, src_ff} < (SRC_W+1)'(SOURCES));
      sts.is_store    = (type_ff == REQ_STORE);
      sts.is_dump     = (type_ff == REQ_DUMP);
      sts.cnt_zero    = (cur_cnt == '0);
      sts.depth_one   = (depth_eff == CNT_W'(1));
      sts.out_free    = out_free;
      sts.pend_valid  = pend_valid_ff;
      sts.can_gen     = !pend_valid_ff || out_free;
      sts.turn_match  = (ram_turn == turn_ff);
      sts.emit_want   = emit_want;
      sts.scan_more   = idx_more && (n_after < limit);
      sts.search_more = idx_more;
   end

   always_comb begin
      if (sts.bad_source) begin
         status_code = ST_BAD_SOURCE;
      end else if (type_ff == REQ_STORE) begin
         status_code = ST_STORED;
      end else begin
         status_code = ST_EMPTY;
      end
   end

   assign push = ((cmd.gen_slot || cmd.gen_current) && pend_valid_ff) || cmd.flush;

   always_comb begin
      if (cmd.gen_status || push) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_comb begin
      if (cmd.capture) begin
         n_in = '0;
      end else if (cmd.gen_current) begin
         n_in = CNT_W'(1);
      end else if (cmd.gen_slot) begin
         n_in = n_ff + CNT_W'(1);
      end else begin
         n_in = n_ff;
      end
   end

   always_comb begin
      wp_in  = (cur_wp == SW'(RING_SIZE - 1)) ? '0 : cur_wp + SW'(1);
      cnt_in = (cur_cnt < CW'(RING_SIZE)) ? cur_cnt + CW'(1) : cur_cnt;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SOURCES; i++) begin
            wp_ff[i]  <= '0;
            cnt_ff[i] <= '0;
         end
         depth_ff      <= DEPTH_RESET;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         found_ff      <= 1'b0;
         n_ff          <= '0;
         idx_ff        <= '0;
      end else begin
         if (csr_valid) begin
            depth_ff <= csr_bundle_depth;
         end
         if (cmd.wr_en && !found_ff) begin
            wp_ff[src_idx]  <= wp_in;
            cnt_ff[src_idx] <= cnt_in;
         end
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.gen_current || cmd.gen_slot) begin
            pend_valid_ff <= 1'b1;
         end else if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
         end
         if (cmd.capture) begin
            found_ff <= 1'b0;
         end else if (cmd.found_set) begin
            found_ff <= 1'b1;
         end
         n_ff   <= n_in;
         idx_ff <= idx_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff    <= req_code_type'(req_type);
         src_ff     <= req_source;
         turn_ff    <= req_turn;
         payload_ff <= req_payload;
      end
      if (cmd.found_set) begin
         found_slot_ff <= idx_ff[SW-1:0];
      end
      if (cmd.gen_current) begin
         pend_turn_ff    <= turn_ff;
         pend_payload_ff <= payload_ff;
         pend_pos_ff     <= '0;
      end else if (cmd.gen_slot) begin
         pend_turn_ff    <= ram_turn;
         pend_payload_ff <= ram_payload;
         pend_pos_ff     <= n_ff[POS_W-1:0];
      end
      if (cmd.gen_status) begin
         rsp_status_ff  <= status_code;
         rsp_turn_ff    <= '0;
         rsp_payload_ff <= '0;
         rsp_pos_ff     <= '0;
         rsp_last_ff    <= 1'b1;
      end else if (push) begin
         rsp_status_ff  <= ST_PACKET;
         rsp_turn_ff    <= pend_turn_ff;
         rsp_payload_ff <= pend_payload_ff;
         rsp_pos_ff     <= pend_pos_ff;
         rsp_last_ff    <= cmd.flush;
      end
   end

   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_turn    = rsp_turn_ff;
   assign rsp_out_payload = rsp_payload_ff;
   assign rsp_position    = rsp_pos_ff;
   assign rsp_last        = rsp_last_ff;

   // An append always leaves the ring with at least one valid slot.
   assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en && !found_ff |=> cur_cnt != '0)
      else $error("append did not raise the valid count");

   // The item counter never runs past the longest sequence.
   assert property (@(posedge clock) disable iff (reset)
      n_ff <= CNT_W'(MAX_OUT))
      else $error("item counter overran");

   // Status results always close their request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_PACKET |-> rsp_last_ff)
      else $error("status result without last");

endmodule

@@ sv/per_source_packet_history_ring.sv @@
// Per-source packet history ring: one request at a time, a new request is taken
// only once the previous one has finished. Stores and bundles search the ring,
// bundles and dumps scan it, through the single read port of the slot RAM, one
// slot a cycle while the result side does not hold up a pending result.
// Synchronous active-high reset empties every ring and sets the bundle depth to 2.
module per_source_packet_history_ring import psphr_pkg::*; #(
   parameter int RING_SIZE = RING_SIZE_DEF,
   parameter int SOURCES   = SOURCES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [REQ_W-1:0]     req_type,
   input  logic [SRC_W-1:0]     req_source,
   input  logic [TURN_W-1:0]    req_turn,
   input  logic [PAYLOAD_W-1:0] req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [TURN_W-1:0]    rsp_out_turn,
   output logic [PAYLOAD_W-1:0] rsp_out_payload,
   output logic [POS_W-1:0]     rsp_position,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [DEPTH_W-1:0]   csr_bundle_depth
);

   cmd_type cmd;
   sts_type sts;

   psphr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   psphr_dp #(
      .RING_SIZE (RING_SIZE),
      .SOURCES   (SOURCES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_type         (req_type),
      .req_source       (req_source),
      .req_turn         (req_turn),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_out_turn     (rsp_out_turn),
      .rsp_out_payload  (rsp_out_payload),
      .rsp_position     (rsp_position),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_bundle_depth (csr_bundle_depth),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule

@@ tb/per_source_packet_history_ring_tb.sv @@
// Self-checking testbench for per_source_packet_history_ring.
// Predicts each ring's contents and every result from the request stream.
// Depends only on psphr_pkg and the block itself.
module per_source_packet_history_ring_tb import psphr_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int IDLE_PAUSE   = 60;
   localparam int DRAIN_CYCLES = 100;
   localparam int LONG_HOLD    = 300;
   localparam int RANDOM_ITEMS = 55;

   typedef struct {
      status_type           status;
      logic [TURN_W-1:0]    turn;
      logic [PAYLOAD_W-1:0] payload;
      logic [POS_W-1:0]     position;
      logic                 last;
   } history_rsp_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [REQ_W-1:0]     req_type;
   logic [SRC_W-1:0]     req_source;
   logic [TURN_W-1:0]    req_turn;
   logic [PAYLOAD_W-1:0] req_payload;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [STATUS_W-1:0]  rsp_status;
   logic [TURN_W-1:0]    rsp_out_turn;
   logic [PAYLOAD_W-1:0] rsp_out_payload;
   logic [POS_W-1:0]     rsp_position;
   logic                 rsp_last;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [DEPTH_W-1:0]   csr_bundle_depth;

   // Predicted history of every source
   logic [TURN_W-1:0]    ring_turn    [SOURCES_DEF][RING_SIZE_DEF];
   logic [PAYLOAD_W-1:0] ring_payload [SOURCES_DEF][RING_SIZE_DEF];
   int                   ring_wr_ptr  [SOURCES_DEF];
   int                   ring_fill    [SOURCES_DEF];
   logic [DEPTH_W-1:0]   depth_setting;

   history_rsp_type awaited_packets[$];

   int  mismatches;
   int  items_sent;
   int  results_checked;
   int  cycle_count;
   bit  sender_eager;
   bit  receiver_eager;
   bit  long_hold;

   per_source_packet_history_ring DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_source       (req_source),
      .req_turn         (req_turn),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_out_turn     (rsp_out_turn),
      .rsp_out_payload  (rsp_out_payload),
      .rsp_position     (rsp_position),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_bundle_depth (csr_bundle_depth)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding",
                  cycle_count, awaited_packets.size());
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic history_rsp_type packet_rsp(status_type st, logic [TURN_W-1:0] t,
                                                  logic [PAYLOAD_W-1:0] p, int pos);
      history_rsp_type r;
      r.status   = st;
      r.turn     = t;
      r.payload  = p;
      r.position = POS_W'(pos);
      r.last     = 1'b0;
      return r;
   endfunction

   function automatic int newest_slot(int s, int age);
      return (ring_wr_ptr[s] + RING_SIZE_DEF - (age % RING_SIZE_DEF) - 1) % RING_SIZE_DEF;
   endfunction

   // A packet of a turn already held replaces that slot's payload in place.
   function automatic void store_in_ring(int s, logic [TURN_W-1:0] t, logic [PAYLOAD_W-1:0] p);
      int i;
      int slot;
      for (i = 0; i < ring_fill[s]; i++) begin
         if (ring_turn[s][i] == t) begin
            ring_payload[s][i] = p;
            return;
         end
      end
      slot = ring_wr_ptr[s];
      ring_turn[s][slot]    = t;
      ring_payload[s][slot] = p;
      ring_wr_ptr[s] = (slot + 1) % RING_SIZE_DEF;
      if (ring_fill[s] < RING_SIZE_DEF)
         ring_fill[s]++;
   endfunction

   function automatic void predict_history(logic [REQ_W-1:0] kind, logic [SRC_W-1:0] src,
                                           logic [TURN_W-1:0] t, logic [PAYLOAD_W-1:0] p);
      history_rsp_type burst[$];
      int s;
      int i;
      int k;
      int limit;
      s = src;
      if (kind == REQ_NONE)
         return;
      if (s >= SOURCES_DEF) begin
         burst.push_back(packet_rsp(ST_BAD_SOURCE, '0, '0, 0));
      end else begin
         case (kind)
            REQ_STORE: begin
               store_in_ring(s, t, p);
               burst.push_back(packet_rsp(ST_STORED, '0, '0, 0));
            end
            REQ_BUNDLE: begin
               limit = depth_setting;
               if (limit < 1)
                  limit = 1;
               if (limit > MAX_OUT)
                  limit = MAX_OUT;
               burst.push_back(packet_rsp(ST_PACKET, t, p, 0));
               for (i = 0; i < ring_fill[s] && burst.size() < limit; i++) begin
                  k = newest_slot(s, i);
                  if (ring_turn[s][k] != t)
                     burst.push_back(packet_rsp(ST_PACKET, ring_turn[s][k], ring_payload[s][k],
                                                burst.size()));
               end
               store_in_ring(s, t, p);
            end
            default: begin
               if (ring_fill[s] == 0) begin
                  burst.push_back(packet_rsp(ST_EMPTY, '0, '0, 0));
               end else begin
                  for (i = 0; i < ring_fill[s] && i < MAX_OUT; i++) begin
                     k = newest_slot(s, i);
                     burst.push_back(packet_rsp(ST_PACKET, ring_turn[s][k], ring_payload[s][k], i));
                  end
               end
            end
         endcase
      end
      burst[burst.size() - 1].last = 1'b1;
      foreach (burst[j])
         awaited_packets.push_back(burst[j]);
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string field, logic [PAYLOAD_W-1:0] got,
                                  logic [PAYLOAD_W-1:0] want);
      $display("Mismatch in %s at result %0d: got %h, expected %h",
               field, results_checked, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : result_check
      history_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (awaited_packets.size() == 0) begin
            report_mismatch("unexpected result, turn", rsp_out_turn, '0);
         end else begin
            want = awaited_packets.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_out_turn !== want.turn)
               report_mismatch("turn", rsp_out_turn, want.turn);
            if (rsp_out_payload !== want.payload)
               report_mismatch("payload", rsp_out_payload, want.payload);
            if (rsp_position !== want.position)
               report_mismatch("position", rsp_position, want.position);
            if (rsp_last !== want.last)
               report_mismatch("last", rsp_last, want.last);
         end
      end
   end

   // Result side: a random hold-off before each item, and one long hold on request.
   initial begin
      int hold;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            long_hold = 1'b0;
         end
         hold = receiver_eager ? 0 : $urandom_range(0, 11);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic send_request(logic [REQ_W-1:0] kind, logic [SRC_W-1:0] src,
                               logic [TURN_W-1:0] t, logic [PAYLOAD_W-1:0] p);
      int gap;
      gap = sender_eager ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_type    <= kind;
      req_source  <= src;
      req_turn    <= t;
      req_payload <= p;
      do @(posedge clock); while (req_stall);
      predict_history(kind, src, t, p);
      items_sent++;
      @(negedge clock);
   endtask

   // The block must be idle: all results in, and time for an ignored item to clear.
   task automatic configure_depth(logic [DEPTH_W-1:0] depth);
      req_valid <= 1'b0;
      while (awaited_packets.size() != 0) @(negedge clock);
      repeat (IDLE_PAUSE) @(negedge clock);
      csr_valid        <= 1'b1;
      csr_bundle_depth <= depth;
      do @(posedge clock); while (!csr_ready);
      depth_setting = depth;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [TURN_W-1:0] pick_turn();
      // Small turns repeat often, so in-place overwrites and skips happen.
      if ($urandom_range(0, 1) == 0)
         return TURN_W'($urandom_range(0, 7));
      return $urandom;
   endfunction

   function automatic logic [PAYLOAD_W-1:0] pick_payload();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [SRC_W-1:0] pick_source(int top);
      if ($urandom_range(0, 9) == 0)
         return SRC_W'($urandom_range(SOURCES_DEF, (1 << SRC_W) - 1));
      return SRC_W'($urandom_range(0, top));
   endfunction

   function automatic logic [REQ_W-1:0] pick_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40)
         return REQ_BUNDLE;
      if (r < 75)
         return REQ_STORE;
      if (r < 95)
         return REQ_DUMP;
      return REQ_NONE;
   endfunction

   task automatic test_invalid_sources();
      send_request(REQ_BUNDLE, SRC_W'(SOURCES_DEF), pick_turn(), pick_payload());
      send_request(REQ_STORE, '1, pick_turn(), pick_payload());
      send_request(REQ_NONE, '1, pick_turn(), pick_payload());
      send_request(REQ_DUMP, SRC_W'(SOURCES_DEF + 1), pick_turn(), pick_payload());
   endtask

   task automatic test_empty_dump();
      send_request(REQ_DUMP, '0, '0, '0);
   endtask

   task automatic test_store_overwrite();
      send_request(REQ_STORE, 4'd1, '0, '0);
      send_request(REQ_STORE, 4'd1, '1, '1);
      send_request(REQ_STORE, 4'd1, '0, 64'h5555_aaaa_5555_aaaa);
      send_request(REQ_DUMP, 4'd1, '0, '0);
   endtask

   // Runs at the reset depth of two; the repeated turn must be skipped.
   task automatic test_bundle_reset_depth();
      send_request(REQ_BUNDLE, 4'd1, 32'd7, pick_payload());
      send_request(REQ_BUNDLE, 4'd1, 32'd7, pick_payload());
      send_request(REQ_NONE, 4'd1, 32'd9, pick_payload());
      send_request(REQ_DUMP, 4'd1, '0, '0);
   endtask

   task automatic test_ring_wrap();
      int i;
      for (i = 0; i < RING_SIZE_DEF + 4; i++)
         send_request(REQ_STORE, 4'd2, 32'h1000 + i + ($urandom & 32'hffff_0000), pick_payload());
      send_request(REQ_DUMP, 4'd2, '0, '0);
   endtask

   task automatic test_depth_settings();
      logic [DEPTH_W-1:0] depths[$];
      int i;
      depths = {5'd0, 5'd1, 5'd31, 5'd17, 5'd16, DEPTH_W'($urandom_range(3, 15)), DEPTH_RESET};
      foreach (depths[d]) begin
         configure_depth(depths[d]);
         for (i = 0; i < 3; i++)
            send_request(REQ_BUNDLE, SRC_W'($urandom_range(0, 3)), pick_turn(), pick_payload());
         send_request(($urandom_range(0, 1) != 0) ? REQ_DUMP : REQ_STORE,
                      SRC_W'($urandom_range(0, 3)), pick_turn(), pick_payload());
      end
   endtask

   // The receiver stops for a long stretch while full-length bundles keep coming.
   task automatic test_backpressure();
      configure_depth(5'd16);
      sender_eager = 1'b1;
      long_hold    = 1'b1;
      send_request(REQ_DUMP, 4'd2, '0, '0);
      send_request(REQ_BUNDLE, 4'd2, $urandom, pick_payload());
      send_request(REQ_BUNDLE, 4'd2, $urandom, pick_payload());
      send_request(REQ_STORE, 4'd3, pick_turn(), pick_payload());
      send_request(REQ_DUMP, 4'd3, '0, '0);
      sender_eager = 1'b0;
   endtask

   task automatic test_random_traffic();
      int i;
      configure_depth(DEPTH_W'($urandom_range(3, 15)));
      sender_eager   = 1'b1;
      receiver_eager = 1'b1;
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 20) begin
            sender_eager   = 1'b0;
            receiver_eager = 1'b0;
         end
         send_request(pick_kind(), pick_source(3), pick_turn(), pick_payload());
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_type         = REQ_NONE;
      req_source       = '0;
      req_turn         = '0;
      req_payload      = '0;
      csr_valid        = 1'b0;
      csr_bundle_depth = DEPTH_RESET;
      depth_setting    = DEPTH_RESET;
      sender_eager     = 1'b0;
      receiver_eager   = 1'b0;
      long_hold        = 1'b0;
      foreach (ring_fill[s]) begin
         ring_fill[s]   = 0;
         ring_wr_ptr[s] = 0;
      end
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_invalid_sources();
      test_empty_dump();
      test_store_overwrite();
      test_bundle_reset_depth();
      test_ring_wrap();
      test_depth_settings();
      test_backpressure();
      test_random_traffic();

      req_valid <= 1'b0;
      while (awaited_packets.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Ran %0d requests giving %0d results, %0d mismatches, in %0d cycles.",
               items_sent, results_checked, mismatches, cycle_count);
      $display("Covered depth clamping, ring wrap, overwrites, bad sources and a long stall.");
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/psphr_pkg.sv
sv/psphr_ram.sv
sv/psphr_ctrl.sv
sv/psphr_dp.sv
sv/per_source_packet_history_ring.sv
tb/per_source_packet_history_ring_tb.sv
